@@ design/sha1md_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-1 digest core package
// Shared types, command codes and the constants of the SHA-1 scheme.
// ----------------------------------------------------------------------------
package sha1md_pkg;

	typedef logic [31:0] word_t;
	typedef logic [4:0][31:0] chain_t;

	// Input kinds carried on the input tuser.
	localparam logic [1:0] MODE_APPEND  = 2'd0;
	localparam logic [1:0] MODE_FINISH  = 2'd1;
	localparam logic [1:0] MODE_DISCARD = 2'd2;

	localparam int unsigned BLOCK_BITS = 512;
	localparam int unsigned ROUNDS     = 80;
	localparam logic [5:0]  LEN_POS    = 6'd56;
	localparam logic [5:0]  LAST_BYTE  = 6'd63;
	localparam logic [7:0]  PAD_MARKER = 8'h80;
	localparam logic [2:0]  LAST_INDEX = 3'd4;

	// Initial chaining value, h0 in the lowest slot.
	localparam chain_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
		32'hEFCDAB89, 32'h67452301};

	localparam word_t K_CH  = 32'h5A827999;
	localparam word_t K_P1  = 32'h6ED9EBA1;
	localparam word_t K_MAJ = 32'h8F1BBCDC;
	localparam word_t K_P2  = 32'hCA62C1D6;

	// Commands from the sequencer to the round unit.
	typedef struct packed {
		logic start;    // load working words and run one compression
		logic restart;  // reload the initial chaining value
	} cmd_t;

	// Byte written into the block buffer.
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} byte_wr_t;

endpackage

@@ design/sha1md_sched.sv @@
// ----------------------------------------------------------------------------
// SHA-1 block buffer and message schedule
// A 512-bit shift line that gathers bytes and then expands the schedule.
// ----------------------------------------------------------------------------
module sha1md_sched (
	input  logic                clk,
	input  sha1md_pkg::byte_wr_t byte_wr,
	input  logic                step,
	output sha1md_pkg::word_t   w_cur
);

	localparam int unsigned TOP = sha1md_pkg::BLOCK_BITS - 1;

	logic [TOP:0]      buf_q;
	sha1md_pkg::word_t w_mix;
	sha1md_pkg::word_t w_new;

	// Word i of the window sits at bits TOP-32*i downward; word 0 is the oldest.
	assign w_cur = buf_q[TOP -: 32];
	assign w_mix = buf_q[TOP - 32*13 -: 32] ^ buf_q[TOP - 32*8 -: 32]
		^ buf_q[TOP - 32*2 -: 32] ^ buf_q[TOP -: 32];
	assign w_new = {w_mix[30:0], w_mix[31]};

	always_ff @(posedge clk) begin
		if (byte_wr.valid) begin
			buf_q <= {buf_q[TOP-8:0], byte_wr.data};
		end else if (step) begin
			buf_q <= {buf_q[TOP-32:0], w_new};
		end
	end

endmodule

@@ design/sha1md_round.sv @@
// ----------------------------------------------------------------------------
// SHA-1 round unit
// One shared round datapath, a round counter and the chaining words.
// ----------------------------------------------------------------------------
module sha1md_round (
	input  logic               clk,
	input  logic               arst_n,
	input  sha1md_pkg::cmd_t   cmd,
	input  sha1md_pkg::word_t  w_cur,
	output logic               step,
	output logic               done,
	output sha1md_pkg::chain_t chain
);

	logic                run_q;
	logic                add_q;
	logic [6:0]          rnd_q;
	sha1md_pkg::chain_t  chain_q;
	sha1md_pkg::word_t   a_q, b_q, c_q, d_q, e_q;
	sha1md_pkg::word_t   f_w, k_w, sum_w;

	assign step  = run_q;
	assign done  = add_q;
	assign chain = chain_q;

	always_comb begin
		if (rnd_q < 7'd20) begin
			f_w = (b_q & c_q) | (~b_q & d_q);
			k_w = sha1md_pkg::K_CH;
		end else if (rnd_q < 7'd40) begin
			f_w = b_q ^ c_q ^ d_q;
			k_w = sha1md_pkg::K_P1;
		end else if (rnd_q < 7'd60) begin
			f_w = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_w = sha1md_pkg::K_MAJ;
		end else begin
			f_w = b_q ^ c_q ^ d_q;
			k_w = sha1md_pkg::K_P2;
		end
		sum_w = {a_q[26:0], a_q[31:27]} + f_w + e_q + w_cur + k_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			add_q   <= 1'b0;
			rnd_q   <= '0;
			chain_q <= sha1md_pkg::H_INIT;
		end else begin
			// The add cycle follows the last round.
			add_q <= run_q && !cmd.restart && !cmd.start
				&& (rnd_q == 7'(sha1md_pkg::ROUNDS - 1));
			if (cmd.restart) begin
				chain_q <= sha1md_pkg::H_INIT;
			end else if (cmd.start) begin
				run_q <= 1'b1;
				rnd_q <= '0;
			end else if (run_q) begin
				rnd_q <= rnd_q + 7'd1;
				if (rnd_q == 7'(sha1md_pkg::ROUNDS - 1)) begin
					run_q <= 1'b0;
				end
			end else if (add_q) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end
		end
	end

	// Working words carry no reset; they are loaded at the start of each block.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (run_q) begin
			a_q <= sum_w;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

endmodule

@@ design/sha1_message_digest_core.sv @@
// ----------------------------------------------------------------------------
// SHA-1 message digest core
// Byte-stream SHA-1 engine with padding, length append and digest readout.
// ----------------------------------------------------------------------------
// An append item that completes a 64-byte block writes its byte and loads the
//   working words together; the rounds and the final add follow.
// A finish item writes padding and length one byte per cycle (9 to 72 bytes),
//   pausing for each of its one or two compressions, then offers five words,
//   one per cycle while m_tready is high. Input waits on the single round unit.
// Reset: arst_n clears the sequencer and counters and loads the initial vector.
// ----------------------------------------------------------------------------
module sha1_message_digest_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_tuser,   // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [2:0]  m_tuser,   // [2:0] word_index
	output logic        m_tlast    // last_word
);

	// Sequencer states.
	localparam logic [1:0] ST_IDLE = 2'd0;  // taking input items
	localparam logic [1:0] ST_PAD  = 2'd1;  // writing marker, zeros and length
	localparam logic [1:0] ST_HASH = 2'd2;  // waiting on the round unit
	localparam logic [1:0] ST_EMIT = 2'd3;  // offering the five digest words

	logic [1:0]  state_q;
	logic [1:0]  ret_q;      // state to resume after the compression
	logic [5:0]  fill_q;     // bytes held in the current block
	logic [60:0] msg_q;      // bytes in the message so far, wraps
	logic        first_q;    // next pad byte is the 0x80 marker
	logic        extra_q;    // padding spills into an extra block
	logic [2:0]  idx_q;      // digest word being offered

	logic                 s_acc;
	logic                 m_acc;
	logic                 len_phase;
	logic [63:0]          bit_len;
	logic [7:0]           pad_byte;
	sha1md_pkg::cmd_t     cmd;
	sha1md_pkg::byte_wr_t byte_wr;
	sha1md_pkg::word_t    w_cur;
	sha1md_pkg::chain_t   chain;
	logic                 step;
	logic                 done;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_EMIT);
	assign m_acc    = m_tvalid && m_tready;
	assign m_tdata  = chain[idx_q];
	assign m_tuser  = idx_q;
	assign m_tlast  = (idx_q == sha1md_pkg::LAST_INDEX);

	// The length occupies the last eight bytes of the final block, most
	// significant byte first, so the low three bits of the fill count pick it.
	assign bit_len   = {msg_q, 3'b000};
	assign len_phase = !first_q && !extra_q && (fill_q >= sha1md_pkg::LEN_POS);

	always_comb begin
		if (first_q) begin
			pad_byte = sha1md_pkg::PAD_MARKER;
		end else if (len_phase) begin
			pad_byte = bit_len[{~fill_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	// Block buffer write: message bytes while idle, padding bytes in ST_PAD.
	always_comb begin
		byte_wr.valid = 1'b0;
		byte_wr.data  = s_tdata;
		if (s_acc && (s_tuser == sha1md_pkg::MODE_APPEND)) begin
			byte_wr.valid = 1'b1;
		end else if (state_q == ST_PAD) begin
			byte_wr.valid = 1'b1;
			byte_wr.data  = pad_byte;
		end
	end

	// A compression starts whenever the 64th byte of a block goes in.
	// The state returns to its reset values on discard and after the last word.
	always_comb begin
		cmd.start   = byte_wr.valid && (fill_q == sha1md_pkg::LAST_BYTE);
		cmd.restart = (s_acc && (s_tuser == sha1md_pkg::MODE_DISCARD))
			|| (m_acc && m_tlast);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			fill_q  <= '0;
			msg_q   <= '0;
			first_q <= 1'b0;
			extra_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						case (s_tuser)
							sha1md_pkg::MODE_APPEND: begin
								fill_q <= fill_q + 6'd1;
								msg_q  <= msg_q + 61'd1;
								if (cmd.start) begin
									state_q <= ST_HASH;
									ret_q   <= ST_IDLE;
								end
							end
							sha1md_pkg::MODE_FINISH: begin
								state_q <= ST_PAD;
								first_q <= 1'b1;
								extra_q <= 1'b0;
							end
							sha1md_pkg::MODE_DISCARD: begin
								fill_q <= '0;
								msg_q  <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_PAD: begin
					fill_q  <= fill_q + 6'd1;
					first_q <= 1'b0;
					if (cmd.start) begin
						state_q <= ST_HASH;
						ret_q   <= (first_q || extra_q) ? ST_PAD : ST_EMIT;
						extra_q <= 1'b0;
					end else if (first_q && (fill_q >= sha1md_pkg::LEN_POS)) begin
						// A marker at or past byte 56 leaves no room for the length.
						extra_q <= 1'b1;
					end
				end
				ST_HASH: begin
					if (done) begin
						state_q <= ret_q;
					end
				end
				ST_EMIT: begin
					if (m_acc) begin
						if (m_tlast) begin
							idx_q   <= '0;
							fill_q  <= '0;
							msg_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	sha1md_sched u_sched (
		.clk     (clk),
		.byte_wr (byte_wr),
		.step    (step),
		.w_cur   (w_cur)
	);

	sha1md_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.w_cur  (w_cur),
		.step   (step),
		.done   (done),
		.chain  (chain)
	);

endmodule

@@ design/sha1md_checker.sv @@
// ----------------------------------------------------------------------------
// SHA-1 digest core port checker
// Watches the ports of the core and flags sequencing errors.
// ----------------------------------------------------------------------------
module sha1md_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);

	// The core never takes input while it offers digest words.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while digest words are offered");

	// The last word flag marks word four and nothing else.
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == sha1md_pkg::LAST_INDEX)))
		else $error("last word flag does not match word index");

	// Words follow in order, one index after another.
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
			(m_tvalid && (m_tuser == $past(m_tuser) + 3'd1)))
		else $error("digest word index out of sequence");

	// After the last word the core returns to taking input.
	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
		else $error("core not idle after the last digest word");

	// A stalled word holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled digest word changed");

endmodule

bind sha1_message_digest_core sha1md_checker u_sha1md_checker (.*);
